/* rtl/core/hha_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package hha_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int POS_W     = 3;
    localparam int SUM_W     = 32;
    localparam int ACC_W     = 64;
    localparam int PROD_W    = 128;
    localparam int DIV_BITS  = 113;
    localparam int DIV_CNT_W = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE_RATE = 3'd0;
    localparam logic [31:0]          BASE_RESET    = 32'd65536;

    localparam logic [1:0] MUL_SQ = 2'd0;
    localparam logic [1:0] MUL_AA = 2'd1;
    localparam logic [1:0] MUL_WY = 2'd2;

    typedef struct packed {
        logic       load;
        logic       sum_step;
        logic       mul_clr;
        logic       mul_step;
        logic [1:0] mul_sel;
        logic       div_init;
        logic       div_step;
        logic       w_load;
        logic       y_load;
        logic       acc_wr;
        logic       entry_next;
        logic       entry_rst;
        logic       out_load;
        logic       clear_valid;
    } cmd_t;

    typedef struct packed {
        logic j_last;
        logic mul_last;
        logic div_last;
        logic entry_last;
        logic last_event;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

/* rtl/core/hha_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface hha_in_if #(parameter int NODES = 4);
    logic                  valid;
    logic                  ready;
    logic [NODES*32-1:0]   sum;
    logic                  last_event;
    modport source (output valid, sum, last_event, input ready);
    modport sink   (input valid, sum, last_event, output ready);
endinterface

interface hha_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  row;
    logic [2:0]  col;
    logic [63:0] value;
    logic        final_entry;
    modport source (output valid, row, col, value, final_entry, input ready);
    modport sink   (input valid, row, col, value, final_entry, output ready);
endinterface

interface hha_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/core/hawkes_hessian_accumulator_top.sv */
// Hessian accumulator for one Hawkes-process node. Each input item carries
// NODES decayed excitation sums (Q16.16) and a last flag; the block forms
// s = mu + sum alpha_j*a_j, the weight 2^112/s^2 (Q16.48, saturating) and
// adds the weighted terms into the (NODES+1)x(NODES+1) upper triangle held
// in a small RAM of E = (NODES+1)(NODES+2)/2 entries. Each item runs the
// sum, a squaring, a 113-step restoring divider and a loop per entry, as
// one shared 32x32 multiplier builds each 64x64 product in four steps.
// On a last item the E entries follow in row-major order, each read from
// the RAM before it is loaded into the output register, then the
// accumulators read as zero again. Configuration writes are always taken.
`timescale 1ns / 1ps
`default_nettype none

module hawkes_hessian_accumulator_top #(
    parameter int NODES = 4
) (
    input  wire logic clk,
    input  wire logic rst_n,
    hha_in_if.sink    in_ch,
    hha_out_if.source out_ch,
    hha_cfg_if.sink   cfg_ch
);
    import hha_pkg::*;

    cmd_t cmd;
    sts_t sts;

    assign cfg_ch.ready = 1'b1;

    hha_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(in_ch.valid),
        .in_ready(in_ch.ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    hha_datapath #(
        .NODES(NODES)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sts      (sts),
        .in_sum   (in_ch.sum),
        .in_last  (in_ch.last_event),
        .cfg_valid(cfg_ch.valid),
        .cfg_index(cfg_ch.index),
        .cfg_data (cfg_ch.data),
        .out_ready(out_ch.ready),
        .out_valid(out_ch.valid),
        .out_row  (out_ch.row),
        .out_col  (out_ch.col),
        .out_value(out_ch.value),
        .out_final(out_ch.final_entry)
    );

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> !in_ch.ready)
        else $error("input accepted while busy");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> sts.out_free)
        else $error("result register overwritten");

    a_one_unit: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.sum_step, cmd.mul_step, cmd.div_step, cmd.acc_wr, cmd.out_load}))
        else $error("datapath steps overlap");
endmodule

`default_nettype wire

/* rtl/core/hha_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module hha_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 15
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

`default_nettype wire

/* rtl/core/hha_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none

module hha_datapath #(
    parameter int NODES = 4
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire hha_pkg::cmd_t         cmd,
    output hha_pkg::sts_t              sts,
    input  wire logic [NODES*32-1:0]   in_sum,
    input  wire logic                  in_last,
    input  wire logic                  cfg_valid,
    input  wire logic [2:0]            cfg_index,
    input  wire logic [31:0]           cfg_data,
    input  wire logic                  out_ready,
    output logic                       out_valid,
    output logic [2:0]                 out_row,
    output logic [2:0]                 out_col,
    output logic [63:0]                out_value,
    output logic                       out_final
);
    import hha_pkg::*;

    localparam int ENTRIES = ((NODES + 1) * (NODES + 2)) / 2;
    localparam int EW      = $clog2(ENTRIES);
    localparam int JW      = (NODES > 1) ? $clog2(NODES) : 1;
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(NODES);

    logic [31:0]          base_reg;
    logic [31:0]          excite_reg [NODES];
    logic [31:0]          a_reg      [NODES];
    logic                 last_reg;
    logic [JW-1:0]        j_reg;
    logic [63:0]          s_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic [1:0]           ph_reg;
    logic [DIV_BITS-1:0]  rem_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [63:0]          q_reg;
    logic [63:0]          w_reg;
    logic [63:0]          y_reg;
    logic [EW-1:0]        e_reg;
    logic [POS_W-1:0]     k_reg;
    logic [POS_W-1:0]     m_reg;
    logic [ENTRIES-1:0]   vld_reg;
    logic                 out_valid_reg;
    logic [2:0]           row_reg;
    logic [2:0]           col_reg;
    logic [63:0]          value_reg;
    logic                 final_reg;

    logic [63:0]          rdata;
    logic [63:0]          acc_old;
    logic [64:0]          s_sum;
    logic [63:0]          sp;
    logic [31:0]          a_k;
    logic [31:0]          a_m;
    logic [63:0]          mx;
    logic [63:0]          my;
    logic [31:0]          opx;
    logic [31:0]          opy;
    logic [63:0]          pp;
    logic [PROD_W-1:0]    pp_sh;
    logic [DIV_BITS-1:0]  rem_sh;
    logic                 rem_ge;
    logic [63:0]          term;
    logic [64:0]          acc_sum;
    logic [63:0]          acc_new;
    logic                 w_sat;
    logic                 w_zero;
    logic                 out_free;

    always_comb
    begin
        sp    = excite_reg[j_reg] * a_reg[j_reg];
        s_sum = {1'b0, s_reg} + {1'b0, sp};
        a_k   = '0;
        a_m   = '0;
        for (int i = 0; i < NODES; i++)
        begin
            if (k_reg == POS_W'(i + 1))
            begin
                a_k = a_reg[i];
            end
            if (m_reg == POS_W'(i + 1))
            begin
                a_m = a_reg[i];
            end
        end
        case (cmd.mul_sel)
            MUL_SQ:
            begin
                mx = s_reg;
                my = s_reg;
            end
            MUL_AA:
            begin
                mx = {32'd0, a_k};
                my = {32'd0, a_m};
            end
            MUL_WY:
            begin
                mx = w_reg;
                my = y_reg;
            end
            default:
            begin
                mx = '0;
                my = '0;
            end
        endcase
        opx = ph_reg[1] ? mx[63:32] : mx[31:0];
        opy = ph_reg[0] ? my[63:32] : my[31:0];
        pp  = opx * opy;
        case (ph_reg)
            2'd0:    pp_sh = {64'd0, pp};
            2'd3:    pp_sh = {pp, 64'd0};
            default: pp_sh = {32'd0, pp, 32'd0};
        endcase
        rem_sh = {rem_reg[DIV_BITS-2:0], (cnt_reg == DIV_CNT_W'(DIV_BITS - 1))};
        rem_ge = rem_sh >= prod_reg[DIV_BITS-1:0];
        w_sat  = prod_reg <= (PROD_W'(1) << 48);
        w_zero = prod_reg > (PROD_W'(1) << 112);
        if (k_reg == '0 && m_reg == '0)
        begin
            term = (prod_reg[127:80] != '0) ? '1 : prod_reg[79:16];
        end
        else if (k_reg == '0)
        begin
            term = (prod_reg[127:96] != '0) ? '1 : prod_reg[95:32];
        end
        else
        begin
            term = (prod_reg[127:112] != '0) ? '1 : prod_reg[111:48];
        end
        acc_old  = vld_reg[e_reg] ? rdata : '0;
        acc_sum  = {1'b0, acc_old} + {1'b0, term};
        acc_new  = acc_sum[64] ? '1 : acc_sum[63:0];
        out_free = !out_valid_reg || out_ready;
    end

    hha_ram #(
        .WIDTH(ACC_W),
        .DEPTH(ENTRIES)
    ) u_acc_ram (
        .clk  (clk),
        .we   (cmd.acc_wr),
        .waddr(e_reg),
        .wdata(acc_new),
        .raddr(e_reg),
        .rdata(rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= BASE_RESET;
            for (int i = 0; i < NODES; i++)
            begin
                excite_reg[i] <= '0;
            end
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_BASE_RATE)
            begin
                base_reg <= cfg_data;
            end
            for (int i = 0; i < NODES; i++)
            begin
                if (cfg_index == CFG_IDX_W'(i + 1))
                begin
                    excite_reg[i] <= cfg_data;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
            e_reg         <= '0;
            k_reg         <= '0;
            m_reg         <= '0;
            j_reg         <= '0;
            ph_reg        <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            if (cmd.sum_step)
            begin
                j_reg <= j_reg + JW'(1);
            end
            if (cmd.load)
            begin
                j_reg <= '0;
            end
            if (cmd.mul_clr)
            begin
                ph_reg <= '0;
            end
            else if (cmd.mul_step)
            begin
                ph_reg <= ph_reg + 2'd1;
            end
            if (cmd.div_init)
            begin
                cnt_reg <= DIV_CNT_W'(DIV_BITS - 1);
            end
            else if (cmd.div_step)
            begin
                cnt_reg <= cnt_reg - DIV_CNT_W'(1);
            end
            if (cmd.acc_wr)
            begin
                vld_reg[e_reg] <= 1'b1;
            end
            if (cmd.clear_valid)
            begin
                vld_reg <= '0;
            end
            if (cmd.load || cmd.entry_rst)
            begin
                e_reg <= '0;
                k_reg <= '0;
                m_reg <= '0;
            end
            else if (cmd.entry_next)
            begin
                e_reg <= e_reg + EW'(1);
                if (m_reg == LAST_POS)
                begin
                    k_reg <= k_reg + POS_W'(1);
                    m_reg <= k_reg + POS_W'(1);
                end
                else
                begin
                    m_reg <= m_reg + POS_W'(1);
                end
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            for (int i = 0; i < NODES; i++)
            begin
                a_reg[i] <= in_sum[i*32 +: 32];
            end
            last_reg <= in_last;
            s_reg    <= {16'd0, base_reg, 16'd0};
        end
        else if (cmd.sum_step)
        begin
            s_reg <= s_sum[64] ? '1 : s_sum[63:0];
        end
        if (cmd.mul_clr)
        begin
            prod_reg <= '0;
        end
        else if (cmd.mul_step)
        begin
            prod_reg <= prod_reg + pp_sh;
        end
        if (cmd.div_init)
        begin
            rem_reg <= '0;
            q_reg   <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_ge ? (rem_sh - prod_reg[DIV_BITS-1:0]) : rem_sh;
            q_reg   <= {q_reg[62:0], rem_ge};
        end
        if (cmd.w_load)
        begin
            w_reg <= w_sat ? '1 : (w_zero ? '0 : q_reg);
        end
        if (cmd.y_load)
        begin
            if (k_reg == '0 && m_reg == '0)
            begin
                y_reg <= 64'd1;
            end
            else if (k_reg == '0)
            begin
                y_reg <= {32'd0, a_m};
            end
            else
            begin
                y_reg <= prod_reg[63:0];
            end
        end
        if (cmd.out_load)
        begin
            row_reg   <= k_reg;
            col_reg   <= m_reg;
            value_reg <= acc_old;
            final_reg <= sts.entry_last;
        end
    end

    assign sts.j_last     = (j_reg == JW'(NODES - 1));
    assign sts.mul_last   = (ph_reg == 2'd3);
    assign sts.div_last   = (cnt_reg == '0);
    assign sts.entry_last = (k_reg == LAST_POS) && (m_reg == LAST_POS);
    assign sts.last_event = last_reg;
    assign sts.out_free   = out_free;

    assign out_valid = out_valid_reg;
    assign out_row   = row_reg;
    assign out_col   = col_reg;
    assign out_value = value_reg;
    assign out_final = final_reg;
endmodule

`default_nettype wire

/* rtl/core/hha_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module hha_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire hha_pkg::sts_t sts,
    output hha_pkg::cmd_t      cmd
);
    import hha_pkg::*;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_SUM  = 4'd1;
    localparam logic [3:0] ST_SQ   = 4'd2;
    localparam logic [3:0] ST_DIVI = 4'd3;
    localparam logic [3:0] ST_DIV  = 4'd4;
    localparam logic [3:0] ST_WLD  = 4'd5;
    localparam logic [3:0] ST_AA   = 4'd6;
    localparam logic [3:0] ST_YLD  = 4'd7;
    localparam logic [3:0] ST_WY   = 4'd8;
    localparam logic [3:0] ST_ACC  = 4'd9;
    localparam logic [3:0] ST_EMRD = 4'd10;
    localparam logic [3:0] ST_EMLD = 4'd11;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_comb
    begin
        cmd        = '0;
        cmd.mul_sel = MUL_SQ;
        in_ready   = 1'b0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                cmd.sum_step = 1'b1;
                if (sts.j_last)
                begin
                    cmd.mul_clr = 1'b1;
                    state_next  = ST_SQ;
                end
            end
            ST_SQ:
            begin
                cmd.mul_step = 1'b1;
                cmd.mul_sel  = MUL_SQ;
                if (sts.mul_last)
                begin
                    state_next = ST_DIVI;
                end
            end
            ST_DIVI:
            begin
                cmd.div_init = 1'b1;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = ST_WLD;
                end
            end
            ST_WLD:
            begin
                cmd.w_load  = 1'b1;
                cmd.mul_clr = 1'b1;
                state_next  = ST_AA;
            end
            ST_AA:
            begin
                cmd.mul_step = 1'b1;
                cmd.mul_sel  = MUL_AA;
                if (sts.mul_last)
                begin
                    state_next = ST_YLD;
                end
            end
            ST_YLD:
            begin
                cmd.y_load  = 1'b1;
                cmd.mul_clr = 1'b1;
                state_next  = ST_WY;
            end
            ST_WY:
            begin
                cmd.mul_step = 1'b1;
                cmd.mul_sel  = MUL_WY;
                if (sts.mul_last)
                begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                cmd.acc_wr = 1'b1;
                if (sts.entry_last)
                begin
                    cmd.entry_rst = 1'b1;
                    state_next    = sts.last_event ? ST_EMRD : ST_IDLE;
                end
                else
                begin
                    cmd.entry_next = 1'b1;
                    cmd.mul_clr    = 1'b1;
                    state_next     = ST_AA;
                end
            end
            ST_EMRD:
            begin
                state_next = ST_EMLD;
            end
            ST_EMLD:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    if (sts.entry_last)
                    begin
                        cmd.clear_valid = 1'b1;
                        cmd.entry_rst   = 1'b1;
                        state_next      = ST_IDLE;
                    end
                    else
                    begin
                        cmd.entry_next = 1'b1;
                        state_next     = ST_EMRD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end
endmodule

`default_nettype wire

/* tb/sv/hha_checker.sv */
`timescale 1ns / 1ps

module hha_checker (
    input  logic clk,
    input  logic rst_n,
    hha_in_if    in_ch,
    hha_out_if   out_ch,
    hha_cfg_if   cfg_ch,
    output int   errors,
    output int   pending
);
    import hha_pkg::*;

    localparam int N       = 4;
    localparam int DIM     = N + 1;
    localparam int ENTRIES = DIM * (DIM + 1) / 2;

    typedef struct packed {
        logic [2:0]  row;
        logic [2:0]  col;
        logic [63:0] value;
        logic        final_entry;
    } entry_t;

    logic [31:0] mu_q;
    logic [31:0] alpha [N];
    logic [63:0] hess [ENTRIES];
    entry_t      hess_q [$];

    function automatic logic [63:0] add_clip(logic [63:0] a, logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? '1 : s[63:0];
    endfunction

    function automatic logic [63:0] inv_square(logic [63:0] s);
        logic [127:0] d;
        d = {64'd0, s} * {64'd0, s};
        if (d <= (128'd1 << 48))
            return '1;
        if (d > (128'd1 << 112))
            return '0;
        return 64'((128'd1 << 112) / d);
    endfunction

    function automatic logic [63:0] clip_shift(logic [127:0] p, int sh);
        logic [127:0] r;
        r = p >> sh;
        return (r[127:64] != 0) ? '1 : r[63:0];
    endfunction

    task automatic accumulate_event(input logic [N*32-1:0] sums, input logic last);
        logic [31:0]  a [N];
        logic [63:0]  s;
        logic [63:0]  w;
        logic [63:0]  term;
        logic [63:0]  aa;
        entry_t       ent;
        int           e;
        for (int j = 0; j < N; j++)
            a[j] = sums[j*32 +: 32];
        s = {16'd0, mu_q, 16'd0};
        for (int j = 0; j < N; j++)
            s = add_clip(s, {32'd0, alpha[j]} * {32'd0, a[j]});
        w = inv_square(s);
        e = 0;
        for (int k = 0; k < DIM; k++)
        begin
            for (int m = k; m < DIM; m++)
            begin
                if (k == 0 && m == 0)
                    term = w >> 16;
                else if (k == 0)
                    term = clip_shift({64'd0, w} * {96'd0, a[m-1]}, 32);
                else
                begin
                    aa   = {32'd0, a[k-1]} * {32'd0, a[m-1]};
                    term = clip_shift({64'd0, w} * {64'd0, aa}, 48);
                end
                hess[e] = add_clip(hess[e], term);
                e++;
            end
        end
        if (last)
        begin
            e = 0;
            for (int k = 0; k < DIM; k++)
            begin
                for (int m = k; m < DIM; m++)
                begin
                    ent.row         = 3'(k);
                    ent.col         = 3'(m);
                    ent.value       = hess[e];
                    ent.final_entry = (e == ENTRIES - 1);
                    hess_q.push_back(ent);
                    hess[e] = '0;
                    e++;
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        entry_t exp_e;
        if (!rst_n)
        begin
            mu_q = BASE_RESET;
            for (int j = 0; j < N; j++)
                alpha[j] = '0;
            for (int e = 0; e < ENTRIES; e++)
                hess[e] = '0;
            hess_q.delete();
            errors = 0;
        end
        else
        begin
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                if (cfg_ch.index == CFG_BASE_RATE)
                    mu_q = cfg_ch.data;
                else if (cfg_ch.index <= 3'(N))
                    alpha[cfg_ch.index - 1] = cfg_ch.data;
            end
            if (out_ch.valid && out_ch.ready)
            begin
                if (hess_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected entry row %0d col %0d value %h", $time,
                             out_ch.row, out_ch.col, out_ch.value);
                end
                else
                begin
                    exp_e = hess_q.pop_front();
                    if (out_ch.row !== exp_e.row)
                    begin
                        errors++;
                        $display("%0t: row expected %0d actual %0d", $time,
                                 exp_e.row, out_ch.row);
                    end
                    if (out_ch.col !== exp_e.col)
                    begin
                        errors++;
                        $display("%0t: col expected %0d actual %0d", $time,
                                 exp_e.col, out_ch.col);
                    end
                    if (out_ch.value !== exp_e.value)
                    begin
                        errors++;
                        $display("%0t: value (%0d,%0d) expected %h actual %h", $time,
                                 exp_e.row, exp_e.col, exp_e.value, out_ch.value);
                    end
                    if (out_ch.final_entry !== exp_e.final_entry)
                    begin
                        errors++;
                        $display("%0t: final_entry expected %0b actual %0b", $time,
                                 exp_e.final_entry, out_ch.final_entry);
                    end
                end
            end
            if (in_ch.valid && in_ch.ready)
                accumulate_event(in_ch.sum, in_ch.last_event);
        end
        pending = hess_q.size();
    end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import hha_pkg::*;

    localparam int N         = 4;
    localparam int SETTLE    = 300;
    localparam int WD_LIMIT  = 5000;

    logic clk = 1'b0;
    logic rst_n;
    int   errors;
    int   pending;
    int   events_sent;
    int   last_sent;
    int   quiet;
    bit   no_idle;

    hha_in_if #(.NODES(N)) in_ch ();
    hha_out_if             out_ch ();
    hha_cfg_if             cfg_ch ();

    hawkes_hessian_accumulator_top #(.NODES(N)) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg_ch (cfg_ch)
    );

    hha_checker chk (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .cfg_ch  (cfg_ch),
        .errors  (errors),
        .pending (pending)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int draw_gap();
        return no_idle ? 0 : $urandom_range(0, 8);
    endfunction

    function automatic logic [31:0] rand_q16();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3:    return $urandom >> $urandom_range(0, 31);
            default: return $urandom_range(0, 1 << 18);
        endcase
    endfunction

    task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge clk); while (!cfg_ch.ready);
    endtask

    task automatic set_config(input logic [31:0] mu, input logic [31:0] a0,
                              input logic [31:0] a1, input logic [31:0] a2,
                              input logic [31:0] a3);
        cfg_write(CFG_BASE_RATE, mu);
        cfg_write(CFG_BASE_RATE + 3'd1, a0);
        cfg_write(CFG_BASE_RATE + 3'd2, a1);
        cfg_write(CFG_BASE_RATE + 3'd3, a2);
        cfg_write(CFG_BASE_RATE + 3'd4, a3);
        if ($urandom_range(0, 1))
            cfg_write(3'($urandom_range(N + 1, 7)), $urandom);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic send_event(input logic [N*32-1:0] sums, input logic last);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.sum        <= sums;
        in_ch.last_event <= last;
        do @(posedge clk); while (!in_ch.ready);
        events_sent++;
        if (last)
            last_sent++;
    endtask

    task automatic send_rand(input logic last);
        logic [N*32-1:0] sums;
        for (int j = 0; j < N; j++)
            sums[j*32 +: 32] = rand_q16();
        send_event(sums, last);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    initial
    begin
        int gap;
        out_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            gap = draw_gap();
            if (gap > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge clk); while (!out_ch.valid);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= WD_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        int n_items;
        events_sent  = 0;
        last_sent    = 0;
        no_idle      = 1'b0;
        rst_n        = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.sum        = '0;
        in_ch.last_event = 1'b0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.index     = '0;
        cfg_ch.data      = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset config: mu = 1.0, no excitation
        send_event('0, 1'b0);
        send_event({N{32'hFFFF_FFFF}}, 1'b0);
        send_event({32'h0001_0000, 32'h0000_0001, 32'h8000_0000, 32'h0000_FFFF}, 1'b1);
        drain();

        // tiny mu: weight saturates
        set_config(32'd1, '0, '0, '0, '0);
        send_event({N{32'h0001_0000}}, 1'b0);
        send_event({N{32'hFFFF_FFFF}}, 1'b1);
        drain();

        // everything at max: intensity saturates, weight zero
        set_config('1, '1, '1, '1, '1);
        send_event({N{32'hFFFF_FFFF}}, 1'b0);
        send_event({32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0000, 32'h0001_0000}, 1'b1);
        drain();

        // zero base rate
        set_config('0, 32'h0000_0001, 32'h0001_0000, 32'h0000_8000, '0);
        send_event('0, 1'b0);
        send_event({32'h0, 32'h0000_0001, 32'h0000_0002, 32'h0000_0004}, 1'b0);
        send_event({32'hFFFF_FFFF, 32'h0, 32'h0001_0000, 32'h0}, 1'b1);
        drain();

        // moderate weights
        set_config(32'h0000_8000, 32'h0000_4000, 32'h0002_0000, 32'h0000_0100,
                   32'h0001_0000);
        for (int i = 0; i < 7; i++)
            send_rand(i == 6);
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            set_config(($urandom_range(0, 3) == 0) ? ($urandom >> $urandom_range(0, 31))
                                                   : $urandom_range(1, 1 << 18),
                       rand_q16(), rand_q16(), rand_q16(), rand_q16());
            no_idle = ($urandom_range(0, 3) == 0);
            n_items = $urandom_range(28, 36);
            for (int i = 0; i < n_items; i++)
                send_rand((i == n_items - 1) || ($urandom_range(0, 5) == 0));
            drain();
            no_idle = 1'b0;
        end

        $display("Sent %0d events, %0d of them closing a sequence, over 11 register settings",
                 events_sent, last_sent);
        $display("including saturated, zero and zero-base-rate weights, with random stalls");
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
